// ===== hw/rtl/olirs_pkg.sv =====
// Shared types and codes for the ordered list block.
`default_nettype none
package olirs_pkg;

    localparam int DEF_DEPTH       = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int MODE_W     = 2;
    localparam int POSITION_W = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_SEARCH = 2'd3
    } t_mode;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        t_mode                 mode;
        logic [POSITION_W-1:0] position;
        logic [VALUE_W-1:0]    value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_res;

    // Commands broadcast to every cell of the row.
    typedef struct packed {
        logic capture;     // register the compare result
        logic shift_up;    // open a slot at the insert position
        logic shift_down;  // close the slot of the first match
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/olirs_cell.sv =====
// One list cell: holds an entry, compares it and shifts with its neighbors.
`default_nettype none
module olirs_cell #(
    parameter int VALUE_WIDTH = olirs_pkg::DEF_VALUE_WIDTH,
    parameter int CNT_W       = 5,
    parameter int INDEX       = 0
) (
    input  wire logic                   i_clk,
    input  wire olirs_pkg::t_cell_ctl   i_ctl,
    input  wire logic [CNT_W-1:0]       i_count,
    input  wire logic [CNT_W-1:0]       i_pos,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_left,
    input  wire logic [VALUE_WIDTH-1:0] i_right,
    input  wire logic                   i_seen,
    output logic [VALUE_WIDTH-1:0]      o_value,
    output logic                        o_seen
);
    import olirs_pkg::*;

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= (r_value == i_value) && (MY_INDEX < i_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_up) begin
            if (MY_INDEX > i_pos) begin
                r_value <= i_left;
            end else if (MY_INDEX == i_pos) begin
                r_value <= i_value;
            end
        end else if (i_ctl.shift_down && o_seen) begin
            // pull the upper neighbor down from the first match onward
            r_value <= i_right;
        end
    end

    assign o_seen  = i_seen | r_match;
    assign o_value = r_value;

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_list_insert_remove_search.sv =====
// Top level of the ordered list: request control, count and the row of cells.
`default_nettype none
// Ordered list of up to DEPTH values with append, insert at position, remove of
// the first match and search. Each request yields one result with a status and
// the count after the operation. A request is taken in S_IDLE; in S_CMP every
// cell compares its entry with the request value, and in S_APPLY the
// first-match chain ripples along the row and the cells shift in place. The
// result sits in an output register; if it is not taken, the next request is
// still accepted and held before its update until the register frees. Entries
// at or above the count never match, so no clearing is needed.
module ordered_list_insert_remove_search #(
    parameter int DEPTH       = olirs_pkg::DEF_DEPTH,
    parameter int VALUE_WIDTH = olirs_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire olirs_pkg::t_req i_req,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output olirs_pkg::t_res      o_res
);
    import olirs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_res             r_res, n_res;

    logic                   out_free, apply;
    logic                   is_put, full, bad_pos, found;
    logic [CNT_W-1:0]       put_pos;
    logic [VALUE_WIDTH-1:0] req_value;
    t_cell_ctl              ctl;

    logic [VALUE_WIDTH-1:0] w_value [DEPTH];
    logic                   w_seen  [DEPTH+1];

    assign req_value = VALUE_WIDTH'(r_req.value);
    assign out_free  = !r_out_valid || i_ready;
    assign apply     = (r_state == S_APPLY) && out_free;

    assign is_put  = (r_req.mode == MODE_APPEND) || (r_req.mode == MODE_INSERT);
    assign full    = (r_count == FULL_COUNT);
    assign bad_pos = (r_req.mode == MODE_INSERT) && (r_count != '0) &&
                     (CMP_W'(r_req.position) > CMP_W'(r_count));
    assign found   = w_seen[DEPTH];

    always_comb begin
        if (r_req.mode == MODE_APPEND) begin
            put_pos = r_count;
        end else if (r_count == '0) begin
            put_pos = '0;
        end else begin
            put_pos = CNT_W'(r_req.position);
        end
    end

    always_comb begin
        ctl.capture    = (r_state == S_CMP);
        ctl.shift_up   = apply && is_put && !full && !bad_pos;
        ctl.shift_down = apply && (r_req.mode == MODE_REMOVE) && found;
    end

    assign w_seen[0] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (gi == 0) begin : g_first
            assign left_value = req_value;
        end else begin : g_mid_l
            assign left_value = w_value[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_value = w_value[gi+1];
        end

        olirs_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_count (r_count),
            .i_pos   (put_pos),
            .i_value (req_value),
            .i_left  (left_value),
            .i_right (right_value),
            .i_seen  (w_seen[gi]),
            .o_value (w_value[gi]),
            .o_seen  (w_seen[gi+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (is_put) begin
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else if (bad_pos) begin
                            n_res.status = ST_MISS;
                        end else begin
                            n_res.status = ST_OK;
                            n_count      = r_count + 1'b1;
                        end
                    end else begin
                        n_res.status = found ? ST_OK : ST_MISS;
                        if ((r_req.mode == MODE_REMOVE) && found) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    n_res.count = COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
        r_res <= n_res;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ($past(r_state) == S_APPLY) &&
            ((r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1)))
        else $error("count moved outside an update or by more than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status == ST_FULL)) |-> (r_count == FULL_COUNT))
        else $error("full status reported with room left");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("control state lost its one-hot code");

endmodule
`default_nettype wire
